// ===== hdl/lvrs_pkg.sv =====
// ----------------------------------------------------------------------------
// lvrs_pkg: shared types and constants for the latest-value ring store
// Request codes, field widths, controller state encoding and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package lvrs_pkg;

    localparam int KEY_W  = 16;
    localparam int UTIL_W = 16;

    // Q1.15 full scale: 1.0
    localparam logic [UTIL_W-1:0] UTIL_ONE = 16'h8000;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    typedef struct packed {
        logic write;     // store the incoming word at the write pointer
        logic start;     // latch the search key and load the scan pointer
        logic step;      // issue one ring read and move toward the oldest entry
        logic cap_hit;   // latch a found result from the current read data
        logic cap_miss;  // latch the result for a scan that ran out of entries
        logic emit;      // move the latched result into the output register
    } t_cmd;

    typedef struct packed {
        logic hit;       // read data is valid and its key matches
        logic exhausted; // no reads left to issue and none in flight
        logic out_free;  // output register can take a word this cycle
    } t_status;

endpackage

// ===== hdl/lvrs_ctrl.sv =====
// ----------------------------------------------------------------------------
// lvrs_ctrl: request sequencer
// Accepts requests, runs the newest-to-oldest scan for reads and hands the
// result to the output register.
// ----------------------------------------------------------------------------
module lvrs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_req_type,
    input  lvrs_pkg::t_status i_status,
    output logic             o_in_stall,
    output lvrs_pkg::t_cmd   o_cmd
);

    lvrs_pkg::t_state r_state;
    lvrs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lvrs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != lvrs_pkg::S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            lvrs_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (i_req_type == lvrs_pkg::REQ_WRITE) begin
                        o_cmd.write = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = lvrs_pkg::S_SCAN;
                    end
                end
            end
            lvrs_pkg::S_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_status.hit) begin
                    o_cmd.cap_hit = 1'b1;
                    n_state       = lvrs_pkg::S_DONE;
                end else if (i_status.exhausted) begin
                    o_cmd.cap_miss = 1'b1;
                    n_state        = lvrs_pkg::S_DONE;
                end
            end
            lvrs_pkg::S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = lvrs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lvrs_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/lvrs_datapath.sv =====
// ----------------------------------------------------------------------------
// lvrs_datapath: ring memory, pointers, key compare and output register
// Holds the key and value rings, the write pointer with a wrap flag, the scan
// pointer and the result registers.
// ----------------------------------------------------------------------------
module lvrs_datapath #(
    parameter int RING_DEPTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lvrs_pkg::t_cmd                i_cmd,
    input  logic [lvrs_pkg::KEY_W-1:0]    i_edge_key,
    input  logic [lvrs_pkg::UTIL_W-1:0]   i_util_in,
    input  logic                          i_out_stall,
    output lvrs_pkg::t_status             o_status,
    output logic                          o_out_valid,
    output logic                          o_found,
    output logic [lvrs_pkg::UTIL_W-1:0]   o_util_out
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(RING_DEPTH - 1);

    logic [lvrs_pkg::KEY_W-1:0]  mem_key [RING_DEPTH];
    logic [lvrs_pkg::UTIL_W-1:0] mem_val [RING_DEPTH];

    logic [AW-1:0]               r_wp;
    logic                        r_full;
    logic [AW-1:0]               r_addr;
    logic [CW-1:0]               r_left;
    logic                        r_rd_vld;
    logic [lvrs_pkg::KEY_W-1:0]  r_key;
    logic [lvrs_pkg::KEY_W-1:0]  r_rd_key;
    logic [lvrs_pkg::UTIL_W-1:0] r_rd_val;
    logic                        r_res_found;
    logic [lvrs_pkg::UTIL_W-1:0] r_res_util;
    logic                        r_out_valid;
    logic                        r_out_found;
    logic [lvrs_pkg::UTIL_W-1:0] r_out_util;

    logic [lvrs_pkg::UTIL_W-1:0] n_util_sat;
    logic [AW-1:0]               n_wp;
    logic [AW-1:0]               n_addr_prev;
    logic [AW-1:0]               n_wp_prev;
    logic [CW-1:0]               n_count;

    assign n_util_sat  = (i_util_in > lvrs_pkg::UTIL_ONE) ? lvrs_pkg::UTIL_ONE : i_util_in;
    assign n_wp        = (r_wp == LAST) ? '0 : r_wp + AW'(1);
    assign n_wp_prev   = (r_wp == '0) ? LAST : r_wp - AW'(1);
    assign n_addr_prev = (r_addr == '0) ? LAST : r_addr - AW'(1);
    // Slots at and above the write pointer are unwritten until the first wrap
    assign n_count     = r_full ? CW'(RING_DEPTH) : CW'(r_wp);

    // Ring memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            mem_key[r_wp] <= i_edge_key;
            mem_val[r_wp] <= n_util_sat;
        end
        if (i_cmd.step) begin
            r_rd_key <= mem_key[r_addr];
            r_rd_val <= mem_val[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_full      <= 1'b0;
            r_left      <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.write) begin
                r_wp <= n_wp;
                if (r_wp == LAST) begin
                    r_full <= 1'b1;
                end
            end
            if (i_cmd.start) begin
                r_left   <= n_count;
                r_rd_vld <= 1'b0;
            end else if (i_cmd.step) begin
                if (r_left != '0) begin
                    r_left   <= r_left - CW'(1);
                    r_rd_vld <= 1'b1;
                end else begin
                    r_rd_vld <= 1'b0;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_key  <= i_edge_key;
            r_addr <= n_wp_prev;
        end else if (i_cmd.step) begin
            r_addr <= n_addr_prev;
        end
        if (i_cmd.cap_hit) begin
            r_res_found <= 1'b1;
            r_res_util  <= r_rd_val;
        end else if (i_cmd.cap_miss) begin
            // Unwritten slots count as key zero with value zero
            r_res_found <= !r_full && (r_key == '0);
            r_res_util  <= '0;
        end
        if (i_cmd.emit) begin
            r_out_found <= r_res_found;
            r_out_util  <= r_res_util;
        end
    end

    assign o_status.hit       = r_rd_vld && (r_rd_key == r_key);
    assign o_status.exhausted = (r_left == '0) && !r_rd_vld;
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_found     = r_out_found;
    assign o_util_out  = r_out_util;

endmodule

// ===== hdl/latest_value_ring_store.sv =====
// Write: completes on acceptance; a write is taken each cycle the store is idle.
// Read: scans newest to oldest, one ring entry per cycle through the single
//   read port of the ring memory; a finished result waits while the output
//   register holds a stalled word.
//   The next request is taken in the cycle the result turns valid.
// Reset (synchronous, active low): empty ring, write pointer zero, no output
//   word; unwritten slots read as key 0, value 0 with no clearing pass.
// ----------------------------------------------------------------------------
// latest_value_ring_store: ring of keyed utilization samples with lookup
// Writes append a key and a saturated Q1.15 value at the write pointer. Reads
// return the value of the newest entry holding the requested key.
// ----------------------------------------------------------------------------
module latest_value_ring_store #(
    parameter int RING_DEPTH = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_req_type,
    input  logic [lvrs_pkg::KEY_W-1:0]  i_edge_key,
    input  logic [lvrs_pkg::UTIL_W-1:0] i_util_in,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_found,
    output logic [lvrs_pkg::UTIL_W-1:0] o_util_out
);

    lvrs_pkg::t_cmd    cmd;
    lvrs_pkg::t_status status;

    // Sequence requests: writes complete on acceptance, reads walk the ring
    // from the newest slot and stop at the first key match or the oldest slot.
    lvrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // Hold the ring, pointers and output register. The output word stays
    // registered, so a waiting result does not block writes that follow it.
    lvrs_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_edge_key  (i_edge_key),
        .i_util_in   (i_util_in),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_found     (o_found),
        .o_util_out  (o_util_out)
    );

endmodule

// ===== hdl/lvrs_checker.sv =====
// ----------------------------------------------------------------------------
// lvrs_checker: port-level checks for the latest-value ring store
// Watches the request and result channels and flags illegal sequences.
// ----------------------------------------------------------------------------
module lvrs_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic                        i_req_type,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic                        o_found,
    input logic [lvrs_pkg::UTIL_W-1:0] o_util_out
);

    // Hold a stalled output word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_found)
            && $stable(o_util_out))
        else $error("output word changed while stalled");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_util_out == '0)
        else $error("miss carries a nonzero value");

    a_util_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_util_out <= lvrs_pkg::UTIL_ONE)
        else $error("value above full scale");

    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_req_type == lvrs_pkg::REQ_READ)
            |=> o_in_stall)
        else $error("request taken during a read scan");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall && !o_out_valid)
        else $error("not idle after reset");

endmodule

bind latest_value_ring_store lvrs_checker u_lvrs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_req_type  (i_req_type),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_found     (o_found),
    .o_util_out  (o_util_out)
);
